// ===== hdl/bpc_pkg.sv =====
// Shared types and constants for the barometer compensation pipeline.
// No dependencies; imported by every module of the block.
package bpc_pkg;

  // Default number of fraction bits on the pressure result.
  localparam int unsigned PressFracBits = 8;

  // Restoring divider: one quotient bit per stage.
  localparam int unsigned DivSteps = 64;

  localparam logic signed [17:0] TempMax = 18'sh1FFFF;
  localparam logic signed [17:0] TempMin = 18'sh20000;
  localparam logic [24:0]        PressMax = 25'h1FFFFFF;

  typedef enum logic [1:0] {
    CFG_TEMP_CALIB = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_MID  = 2'd2,
    CFG_PRESS_HIGH = 2'd3
  } cfg_idx_e;

  // Sideband that travels alongside the divider and the wide multiplier.
  typedef struct packed {
    logic               neg;
    logic               ok;
    logic signed [17:0] temp;
  } side_t;

  typedef struct packed {
    logic signed [17:0] temp;
    logic [24:0]        press;
    logic               pv;
  } result_t;

endpackage

// ===== hdl/bpc_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Built from three 32x32 partial products; uses bpc_pkg.
module bpc_mul64 #(
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  input  logic [SideW-1:0]  side_i,
  output logic              vld_o,
  output logic [63:0]       prod_o,
  output logic [SideW-1:0]  side_o
);
  import bpc_pkg::*;

  logic [63:0]      ll_q;
  logic [31:0]      lh_q, hl_q;
  logic [SideW-1:0] side_a_q, side_b_q;
  logic             vld_a_q, vld_b_q;
  logic [63:0]      prod_q;
  logic [63:0]      ll_d, lh_full, hl_full;

  // Only the low halves of the cross terms reach the kept 64 bits.
  assign ll_d    = a_i[31:0] * b_i[31:0];
  assign lh_full = a_i[31:0] * b_i[63:32];
  assign hl_full = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q     <= ll_d;
      lh_q     <= lh_full[31:0];
      hl_q     <= hl_full[31:0];
      side_a_q <= side_i;
      prod_q   <= ll_q + {lh_q + hl_q, 32'h0};
      side_b_q <= side_a_q;
    end
  end

  assign vld_o  = vld_b_q;
  assign prod_o = prod_q;
  assign side_o = side_b_q;

endmodule

// ===== hdl/bpc_div.sv =====
// Pipelined restoring divider: 64-bit unsigned dividend by a 31-bit divisor.
// One quotient bit per stage, DivSteps stages; uses bpc_pkg.
module bpc_div #(
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [63:0]       dividend_i,
  input  logic [30:0]       divisor_i,
  input  logic [SideW-1:0]  side_i,
  output logic              vld_o,
  output logic [63:0]       quot_o,
  output logic [SideW-1:0]  side_o
);
  import bpc_pkg::*;

  logic [30:0]      rem_q  [DivSteps];
  logic [63:0]      work_q [DivSteps];
  logic [30:0]      dvs_q  [DivSteps];
  logic [SideW-1:0] side_q [DivSteps];
  logic             vld_q  [DivSteps];

  logic [30:0]      rem_in  [DivSteps];
  logic [63:0]      work_in [DivSteps];
  logic [30:0]      dvs_in  [DivSteps];
  logic [SideW-1:0] side_in [DivSteps];
  logic             vld_in  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign work_in[k] = dividend_i;
      assign dvs_in[k]  = divisor_i;
      assign side_in[k] = side_i;
      assign vld_in[k]  = vld_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign work_in[k] = work_q[k-1];
      assign dvs_in[k]  = dvs_q[k-1];
      assign side_in[k] = side_q[k-1];
      assign vld_in[k]  = vld_q[k-1];
    end

    // The remainder stays below the divisor, so the trial value fits 32 bits.
    assign trial = {rem_in[k], work_in[k][63]};
    assign ge    = (trial >= {1'b0, dvs_in[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 31'(trial - {1'b0, dvs_in[k]}) : trial[30:0];
        work_q[k] <= {work_in[k][62:0], ge};
        dvs_q[k]  <= dvs_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign vld_o  = vld_q[DivSteps-1];
  assign quot_o = work_q[DivSteps-1];
  assign side_o = side_q[DivSteps-1];

endmodule

// ===== hdl/barometric_pressure_compensation_top.sv =====
// Barometer temperature and pressure compensation, top level.
// Depends on bpc_pkg, bpc_div and bpc_mul64.
//
// Each accepted pair of raw readings yields one result, and a
// new pair can be accepted every cycle. The pipeline has eleven stages of
// temperature and divisor arithmetic, the 64-stage restoring divider (one
// quotient bit per stage), and six stages of pressure correction including the
// two-stage wide multiplier. A skid register at the output lets one transfer
// be taken while a result waits; the whole pipeline then holds until it drains.
// Calibration registers must only be written while the pipeline is empty.
module barometric_pressure_compensation_top #(
  parameter int unsigned PRESSURE_FRACTION_BITS = bpc_pkg::PressFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [19:0]        temp_raw_i,
  input  logic [19:0]        press_raw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] temperature_centi_o,
  output logic [24:0]        pressure_q24_8_o,
  output logic               press_valid_o
);
  import bpc_pkg::*;

  localparam int unsigned PrShift = 8 - PRESSURE_FRACTION_BITS;
  localparam int unsigned SideW   = $bits(side_t);
  localparam int unsigned MulSideW = 128 + SideW;

  // Calibration registers.
  logic [47:0] tcal_q;
  logic [63:0] pcal_lo_q, pcal_mid_q;
  logic [15:0] pcal_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q     <= '0;
      pcal_lo_q  <= '0;
      pcal_mid_q <= '0;
      pcal_hi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP_CALIB: tcal_q     <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  pcal_lo_q  <= cfg_data_i;
        CFG_PRESS_MID:  pcal_mid_q <= cfg_data_i;
        CFG_PRESS_HIGH: pcal_hi_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = tcal_q[15:0];
  assign t2 = $signed(tcal_q[31:16]);
  assign t3 = $signed(tcal_q[47:32]);
  assign p1 = pcal_lo_q[15:0];
  assign p2 = $signed(pcal_lo_q[31:16]);
  assign p3 = $signed(pcal_lo_q[47:32]);
  assign p4 = $signed(pcal_lo_q[63:48]);
  assign p5 = $signed(pcal_mid_q[15:0]);
  assign p6 = $signed(pcal_mid_q[31:16]);
  assign p7 = $signed(pcal_mid_q[47:32]);
  assign p8 = $signed(pcal_mid_q[63:48]);
  assign p9 = $signed(pcal_hi_q);

  logic en;
  logic skid_vld_q;
  result_t skid_q;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // Valid bits for stages 1 to 11.
  logic [11:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[10:1], in_valid_i & in_ready_o};
    end
  end

  // Stage 1 to 5: temperature.
  logic signed [18:0] x1_d, x1_q;
  logic signed [17:0] dt_d, dt_q;
  logic signed [34:0] m1_d, m1_q;
  logic signed [35:0] dd_d, dd_q;
  logic signed [23:0] v1_d, v1_q;
  logic signed [39:0] m2_d, m2_q;
  logic signed [31:0] tfine_d, tfine_q;
  logic signed [35:0] tscaled;
  logic signed [27:0] tshift;
  logic signed [17:0] temp_d, temp5_q;
  logic signed [31:0] a_d, a_q;
  logic [19:0]        adcp1_q, adcp2_q, adcp3_q, adcp4_q, adcp5_q, adcp6_q, adcp7_q, adcp8_q;

  assign x1_d = $signed({2'b00, temp_raw_i[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign dt_d = $signed({2'b00, temp_raw_i[19:4]}) - $signed({2'b00, t1});
  assign m1_d = x1_q * t2;
  assign dd_d = dt_q * dt_q;
  assign v1_d = $signed(m1_q[34:11]);
  assign m2_d = $signed(dd_q[35:12]) * t3;
  assign tfine_d = v1_q + $signed(m2_q[39:14]);
  assign tscaled = tfine_q * 36'sd5 + 36'sd128;
  assign tshift  = $signed(tscaled[35:8]);
  assign a_d     = tfine_q - 32'sd128000;

  always_comb begin
    if (tshift > TempMax) begin
      temp_d = TempMax;
    end else if (tshift < TempMin) begin
      temp_d = TempMin;
    end else begin
      temp_d = tshift[17:0];
    end
  end

  // Stage 6 to 10: divisor and dividend of the pressure quotient.
  logic signed [63:0] aa_d, aa_q;
  logic signed [47:0] ap5_d, ap5_q, ap2_d, ap2_q, ap5b_q, ap2b_q;
  logic signed [63:0] bp_d, bp_q, cp_d, cp_q;
  logic signed [63:0] ap5x, ap2x, p4x;
  logic signed [63:0] b_d, b_q, a2_d, a2_q;
  logic [20:0]        pd;
  logic [63:0]        n0_d, n0_q, prod_d, prod_q, n1_d, n1_q;
  logic [30:0]        dv_q;
  logic signed [17:0] temp6_q, temp7_q, temp8_q, temp9_q, temp10_q;

  assign aa_d  = a_q * a_q;
  assign ap5_d = a_q * p5;
  assign ap2_d = a_q * p2;
  assign bp_d  = aa_q * p6;
  assign cp_d  = aa_q * p3;
  assign ap5x  = ap5b_q;
  assign ap2x  = ap2b_q;
  assign p4x   = p4;
  assign b_d   = bp_q + (ap5x <<< 17) + (p4x <<< 35);
  assign a2_d  = (cp_q >>> 8) + (ap2x <<< 12);
  assign pd    = 21'h100000 - {1'b0, adcp8_q};
  assign n0_d  = ({43'h0, pd} << 31) - b_q;
  assign prod_d = (64'h0000_8000_0000_0000 + a2_q) * {48'h0, p1};
  assign n1_d  = n0_q * 64'd3125;

  // Stage 11: signs and magnitudes for the divider.
  logic        neg11_q, ok11_q;
  logic [63:0] na11_q;
  logic [30:0] da11_q;
  logic signed [17:0] temp11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= x1_d;
      dt_q     <= dt_d;
      adcp1_q  <= press_raw_i;
      m1_q     <= m1_d;
      dd_q     <= dd_d;
      adcp2_q  <= adcp1_q;
      v1_q     <= v1_d;
      m2_q     <= m2_d;
      adcp3_q  <= adcp2_q;
      tfine_q  <= tfine_d;
      adcp4_q  <= adcp3_q;
      temp5_q  <= temp_d;
      a_q      <= a_d;
      adcp5_q  <= adcp4_q;
      aa_q     <= aa_d;
      ap5_q    <= ap5_d;
      ap2_q    <= ap2_d;
      temp6_q  <= temp5_q;
      adcp6_q  <= adcp5_q;
      bp_q     <= bp_d;
      cp_q     <= cp_d;
      ap5b_q   <= ap5_q;
      ap2b_q   <= ap2_q;
      temp7_q  <= temp6_q;
      adcp7_q  <= adcp6_q;
      b_q      <= b_d;
      a2_q     <= a2_d;
      temp8_q  <= temp7_q;
      adcp8_q  <= adcp7_q;
      n0_q     <= n0_d;
      prod_q   <= prod_d;
      temp9_q  <= temp8_q;
      n1_q     <= n1_d;
      dv_q     <= prod_q[63:33];
      temp10_q <= temp9_q;
      neg11_q  <= n1_q[63] ^ dv_q[30];
      ok11_q   <= |dv_q;
      na11_q   <= n1_q[63] ? -n1_q : n1_q;
      da11_q   <= dv_q[30] ? -dv_q : dv_q;
      temp11_q <= temp10_q;
    end
  end

  // Divider. A zero divisor yields a quotient that is discarded later.
  side_t side11, div_side;
  logic  div_vld;
  logic [63:0] quot;

  assign side11 = '{neg: neg11_q, ok: ok11_q, temp: temp11_q};

  bpc_div #(
    .SideW (SideW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (vld_q[11]),
    .dividend_i (na11_q),
    .divisor_i  (da11_q),
    .side_i     (side11),
    .vld_o      (div_vld),
    .quot_o     (quot),
    .side_o     (div_side)
  );

  // Stage Q and R1: signed quotient, then the first correction products.
  logic               q_vld_q, r1_vld_q, r4_vld_q, r5_vld_q;
  logic signed [63:0] p_q, pr1_q, s_q, ps_q, v2p_q;
  logic signed [50:0] s_d;
  logic signed [63:0] ps_d, v2p_d;
  side_t              q_side_q, r1_side_q;

  assign s_d   = $signed(p_q[63:13]);
  assign ps_d  = s_d * p9;
  assign v2p_d = p_q * p8;

  // Stage R2 and R3: the wide product p9 * s * s.
  logic        mul_vld;
  logic [63:0] mul_prod;
  logic [MulSideW-1:0] mul_side;
  logic signed [63:0]  mp_p, mp_v2p;
  side_t               mp_side;

  bpc_mul64 #(
    .SideW (MulSideW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (r1_vld_q),
    .a_i    (ps_q),
    .b_i    (s_q),
    .side_i ({pr1_q, v2p_q, r1_side_q}),
    .vld_o  (mul_vld),
    .prod_o (mul_prod),
    .side_o (mul_side)
  );

  assign {mp_p, mp_v2p, mp_side} = mul_side;

  // Stage R4 and R5: sum, offset, scaling and saturation.
  logic signed [63:0] sum_d, sum_q, p7x, pp, prs;
  side_t              r4_side_q;
  logic [24:0]        press_d;
  result_t            r5_q;

  assign sum_d = mp_p + ($signed(mul_prod) >>> 25) + (mp_v2p >>> 19);
  assign p7x   = p7;
  assign pp    = (sum_q >>> 8) + (p7x <<< 4);
  assign prs   = pp >>> PrShift;

  always_comb begin
    if (!r4_side_q.ok || prs[63]) begin
      press_d = '0;
    end else if (prs > $signed({39'h0, PressMax})) begin
      press_d = PressMax;
    end else begin
      press_d = prs[24:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q  <= 1'b0;
      r1_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      r5_vld_q <= 1'b0;
    end else if (en) begin
      q_vld_q  <= div_vld;
      r1_vld_q <= q_vld_q;
      r4_vld_q <= mul_vld;
      r5_vld_q <= r4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q       <= div_side.neg ? -$signed(quot) : $signed(quot);
      q_side_q  <= div_side;
      s_q       <= s_d;
      ps_q      <= ps_d;
      v2p_q     <= v2p_d;
      pr1_q     <= p_q;
      r1_side_q <= q_side_q;
      sum_q     <= sum_d;
      r4_side_q <= mp_side;
      r5_q      <= '{temp: r4_side_q.temp, press: press_d, pv: r4_side_q.ok};
    end
  end

  // Output skid register: catches the result leaving the pipeline when the
  // downstream transfer stalls, and freezes the pipeline until it drains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      skid_vld_q <= !out_ready_i;
    end else begin
      skid_vld_q <= r5_vld_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_q <= r5_q;
    end
  end

  result_t out_sel;

  assign out_sel             = skid_vld_q ? skid_q : r5_q;
  assign out_valid_o         = skid_vld_q | r5_vld_q;
  assign temperature_centi_o = out_sel.temp;
  assign pressure_q24_8_o    = out_sel.press;
  assign press_valid_o       = out_sel.pv;

  a_zero_press_when_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !press_valid_o |-> pressure_q24_8_o == '0)
    else $error("pressure not zero on a result with a zero divisor");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(r5_vld_q && !out_ready_i))
    else $error("skid register filled without a stalled result");

  a_pipe_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(r5_vld_q))
    else $error("pipeline moved while the skid register was full");

endmodule
